@@ rtl/sorted_key_equal_range_search_macros.svh @@
// assertion macros shared by the equal-range search rtl
`ifndef SORTED_KEY_EQUAL_RANGE_SEARCH_MACROS_SVH
`define SORTED_KEY_EQUAL_RANGE_SEARCH_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off during rst
`define SKER_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication, sampled on clk, off during rst
`define SKER_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SKER_ASSERT_IMPL(lbl, ante, cons)
`define SKER_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/sker_pkg.sv @@
// types and constants of the equal-range search block
package sker_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int KEY_W       = 32;
  localparam int OUT_IDX_W   = 11;

  // commands
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;

  // declared table order
  localparam logic [1:0] ORDER_FIRST  = 2'd1;
  localparam logic [1:0] ORDER_SECOND = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_UNSORTED  = 2'd1;
  localparam logic [1:0] STATUS_BAD_RANGE = 2'd2;
  localparam logic [1:0] STATUS_FULL      = 2'd3;

  // index values reported when nothing matches
  localparam logic signed [OUT_IDX_W-1:0] NONE_LOWER = -11'sd1;
  localparam logic signed [OUT_IDX_W-1:0] NONE_UPPER = -11'sd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_LEFT,
    S_RIGHT,
    S_DONE
  } state_t;

endpackage

@@ rtl/sker_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
module sker_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/sorted_key_equal_range_search.sv @@
// Equal-range search over a table of up to 1024 entries of two signed 32-bit keys, both keys
// of an entry held in one 64-bit wide ram with a single registered read port. Clear, append
// and unused commands go from idle straight to the done state. A search reads the ram once per
// step: at most 11 probes of the binary search, then one read per duplicate found on each side
// plus one closing read per side. One item is worked on at a time; a finished result waits in
// the output register, so the next item is taken while it is stalled.
module sorted_key_equal_range_search (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration
  input  logic                                  cfg_wr_en,
  input  logic [1:0]                            cfg_wr_data,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            command,
  input  logic signed [sker_pkg::KEY_W-1:0]     entry_first_key,
  input  logic signed [sker_pkg::KEY_W-1:0]     entry_second_key,
  input  logic                                  key_select,
  input  logic signed [sker_pkg::KEY_W-1:0]     search_key,
  input  logic [sker_pkg::IDX_W-1:0]            range_from,
  input  logic [sker_pkg::IDX_W-1:0]            range_upto,
  input  logic                                  upto_is_end,
  // output channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  found,
  output logic signed [sker_pkg::OUT_IDX_W-1:0] lower_index,
  output logic signed [sker_pkg::OUT_IDX_W-1:0] upper_index,
  output logic [1:0]                            status
);

  `include "sorted_key_equal_range_search_macros.svh"

  localparam int IDX_W = sker_pkg::IDX_W;
  localparam int CNT_W = sker_pkg::CNT_W;
  localparam int KEY_W = sker_pkg::KEY_W;
  localparam int OW    = sker_pkg::OUT_IDX_W;

  sker_pkg::state_t state, state_next;

  logic [1:0]       sorted_order;
  logic [CNT_W-1:0] entry_count, entry_count_next;

  // search registers: window is lo_p..up-1
  logic             sel, sel_next;
  logic [KEY_W-1:0] target, target_next;
  logic [CNT_W-1:0] lo_p, lo_p_next;
  logic [CNT_W-1:0] up, up_next;
  logic [IDX_W-1:0] lb, lb_next;
  logic [IDX_W-1:0] ub, ub_next;

  // pending result
  logic                 res_found, res_found_next;
  logic signed [OW-1:0] res_lower, res_lower_next;
  logic signed [OW-1:0] res_upper, res_upper_next;
  logic [1:0]           res_status, res_status_next;

  // ram ports
  logic                   ram_wr_en;
  logic [IDX_W-1:0]       ram_rd_addr;
  logic [2*KEY_W-1:0]     ram_rd_data;
  logic [KEY_W-1:0]       probe_key;
  logic                   key_eq;
  logic                   key_gt;

  logic             load_out;
  logic [1:0]       order_expected;
  logic [CNT_W-1:0] upto_eff;
  logic             range_bad;
  logic             go_right;

  sker_ram #(
    .WIDTH (2 * KEY_W),
    .DEPTH (sker_pkg::TABLE_DEPTH)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (entry_count[IDX_W-1:0]),
    .wr_data ({entry_second_key, entry_first_key}),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // key read back from the ram and its comparison with the target
  assign probe_key = sel ? ram_rd_data[2*KEY_W-1:KEY_W] : ram_rd_data[KEY_W-1:0];
  assign key_eq    = (probe_key == target);
  assign key_gt    = ($signed(target) > $signed(probe_key));

  // query checks on the incoming item
  assign order_expected = key_select ? sker_pkg::ORDER_SECOND : sker_pkg::ORDER_FIRST;
  assign upto_eff  = upto_is_end ? (entry_count - CNT_W'(1)) : {1'b0, range_upto};
  assign range_bad = (upto_eff >= entry_count) || ({1'b0, range_from} > upto_eff);

  assign in_stall = (state != sker_pkg::S_IDLE);
  assign load_out = (state == sker_pkg::S_DONE) && (!out_valid || !out_stall);

  // next state and search steps
  always_comb begin
    logic [CNT_W:0] win_sum;
    state_next       = state;
    entry_count_next = entry_count;
    sel_next         = sel;
    target_next      = target;
    lo_p_next        = lo_p;
    up_next          = up;
    lb_next          = lb;
    ub_next          = ub;
    res_found_next   = res_found;
    res_lower_next   = res_lower;
    res_upper_next   = res_upper;
    res_status_next  = res_status;
    ram_wr_en        = 1'b0;
    ram_rd_addr      = lb;
    go_right         = 1'b0;
    win_sum          = '0;

    case (state)
      sker_pkg::S_IDLE: begin
        if (in_valid) begin
          res_found_next  = 1'b0;
          res_lower_next  = sker_pkg::NONE_LOWER;
          res_upper_next  = sker_pkg::NONE_UPPER;
          res_status_next = sker_pkg::STATUS_OK;
          state_next      = sker_pkg::S_DONE;
          case (command)
            sker_pkg::CMD_CLEAR: begin
              entry_count_next = '0;
            end
            sker_pkg::CMD_APPEND: begin
              if (entry_count == CNT_W'(sker_pkg::TABLE_DEPTH)) begin
                res_status_next = sker_pkg::STATUS_FULL;
              end else begin
                ram_wr_en        = 1'b1;
                entry_count_next = entry_count + CNT_W'(1);
              end
            end
            sker_pkg::CMD_SEARCH: begin
              sel_next    = key_select;
              target_next = search_key;
              if (sorted_order != order_expected) begin
                res_status_next = sker_pkg::STATUS_UNSORTED;
              end else if (entry_count == '0) begin
                res_status_next = sker_pkg::STATUS_OK;
              end else if (range_bad) begin
                res_status_next = sker_pkg::STATUS_BAD_RANGE;
              end else begin
                lo_p_next   = {1'b0, range_from};
                up_next     = upto_eff + CNT_W'(1);
                win_sum     = {2'b00, range_from} + {1'b0, upto_eff};
                ram_rd_addr = win_sum[IDX_W:1];
                lb_next     = win_sum[IDX_W:1];
                state_next  = sker_pkg::S_PROBE;
              end
            end
            default: begin
              state_next = sker_pkg::S_DONE;
            end
          endcase
        end
      end

      // lb holds the probed midpoint while the binary search runs
      sker_pkg::S_PROBE: begin
        if (key_eq) begin
          ub_next  = lb;
          if ({1'b0, lb} > lo_p) begin
            ram_rd_addr = lb - IDX_W'(1);
            state_next  = sker_pkg::S_LEFT;
          end else begin
            go_right = 1'b1;
          end
        end else begin
          if (key_gt) begin
            lo_p_next = {1'b0, lb} + CNT_W'(1);
          end else begin
            up_next = {1'b0, lb};
          end
          if (up_next > lo_p_next) begin
            win_sum     = {1'b0, lo_p_next} + {1'b0, up_next} - (CNT_W + 1)'(1);
            ram_rd_addr = win_sum[IDX_W:1];
            lb_next     = win_sum[IDX_W:1];
          end else begin
            state_next = sker_pkg::S_DONE;
          end
        end
      end

      // widen toward lower indices
      sker_pkg::S_LEFT: begin
        if (key_eq) begin
          lb_next = lb - IDX_W'(1);
          if ({1'b0, lb_next} > lo_p) begin
            ram_rd_addr = lb_next - IDX_W'(1);
          end else begin
            go_right = 1'b1;
          end
        end else begin
          go_right = 1'b1;
        end
      end

      // widen toward higher indices
      sker_pkg::S_RIGHT: begin
        if (key_eq) begin
          ub_next = ub + IDX_W'(1);
          if (({1'b0, ub_next} + CNT_W'(1)) < up) begin
            ram_rd_addr = ub_next + IDX_W'(1);
          end else begin
            res_found_next  = 1'b1;
            res_lower_next  = OW'({1'b0, lb_next});
            res_upper_next  = OW'({1'b0, ub_next});
            res_status_next = sker_pkg::STATUS_OK;
            state_next      = sker_pkg::S_DONE;
          end
        end else begin
          res_found_next  = 1'b1;
          res_lower_next  = OW'({1'b0, lb_next});
          res_upper_next  = OW'({1'b0, ub_next});
          res_status_next = sker_pkg::STATUS_OK;
          state_next      = sker_pkg::S_DONE;
        end
      end

      sker_pkg::S_DONE: begin
        if (load_out) begin
          state_next = sker_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = sker_pkg::S_IDLE;
      end
    endcase

    // lower edge settled: start the upper side or finish
    if (go_right) begin
      if (({1'b0, ub_next} + CNT_W'(1)) < up) begin
        ram_rd_addr = ub_next + IDX_W'(1);
        state_next  = sker_pkg::S_RIGHT;
      end else begin
        res_found_next  = 1'b1;
        res_lower_next  = OW'({1'b0, lb_next});
        res_upper_next  = OW'({1'b0, ub_next});
        res_status_next = sker_pkg::STATUS_OK;
        state_next      = sker_pkg::S_DONE;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= sker_pkg::S_IDLE;
      entry_count  <= '0;
      sorted_order <= '0;
      out_valid    <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      if (cfg_wr_en) begin
        sorted_order <= cfg_wr_data;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // search and result payload registers
  always_ff @(posedge clk) begin
    sel        <= sel_next;
    target     <= target_next;
    lo_p       <= lo_p_next;
    up         <= up_next;
    lb         <= lb_next;
    ub         <= ub_next;
    res_found  <= res_found_next;
    res_lower  <= res_lower_next;
    res_upper  <= res_upper_next;
    res_status <= res_status_next;
    if (load_out) begin
      found       <= res_found;
      lower_index <= res_lower;
      upper_index <= res_upper;
      status      <= res_status;
    end
  end

  // checks
  `SKER_ASSERT_IMPL(a_count_in_range, 1'b1, entry_count <= CNT_W'(sker_pkg::TABLE_DEPTH))
  `SKER_ASSERT_IMPL(a_probe_window, state == sker_pkg::S_PROBE, up > lo_p)
  `SKER_ASSERT_IMPL(a_miss_indices, out_valid && !found,
                    (lower_index == sker_pkg::NONE_LOWER) &&
                    (upper_index == sker_pkg::NONE_UPPER))
  `SKER_ASSERT_IMPL(a_hit_order, out_valid && found,
                    (lower_index <= upper_index) && (status == sker_pkg::STATUS_OK))
  `SKER_ASSERT_NEXT(a_append_count,
                    in_valid && !in_stall && (command == sker_pkg::CMD_APPEND) &&
                    (entry_count < CNT_W'(sker_pkg::TABLE_DEPTH)),
                    entry_count == $past(entry_count) + CNT_W'(1))

endmodule
